// ----- design/smp_pkg.sv -----
// ----------------------------------------------------------------------------
// smp_pkg: shared types and constants for the straight-drive motion profile
// Holds the defaults of the parameters, register indexes, profile modes, the
// controller states and the command and status groups.
// ----------------------------------------------------------------------------
package smp_pkg;

  localparam int POS_BITS_DEF       = 24;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int DRIVE_MAX = 12000;
  localparam int BOOST_CAP = 65536;
  localparam int MIN_MV    = 2160;
  localparam int LONG_CM   = 25;
  localparam int BIG_DRIFT = 1600;

  // configuration register indexes
  localparam logic [2:0] CFG_DISTANCE = 3'd0;
  localparam logic [2:0] CFG_SPEED    = 3'd1;
  localparam logic [2:0] CFG_REVERSE  = 3'd2;
  localparam logic [2:0] CFG_MODE     = 3'd3;
  localparam logic [2:0] CFG_CPC      = 3'd4;

  // profile modes
  localparam logic [2:0] MODE_FULL      = 3'd0;
  localparam logic [2:0] MODE_ACCEL     = 3'd1;
  localparam logic [2:0] MODE_CONST     = 3'd2;
  localparam logic [2:0] MODE_DECEL     = 3'd3;
  localparam logic [2:0] MODE_ACC_CONST = 3'd4;

  typedef enum logic [1:0] {
    BR_END,
    BR_CONST,
    BR_ACC,
    BR_DEC
  } branch_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P1,
    S_P2,
    S_B0,
    S_BWAIT,
    S_GAIN,
    S_M1,
    S_M2,
    S_M3,
    S_PROF,
    S_PD0,
    S_PWAIT,
    S_FIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic prep1;
    logic prep2;
    logic div_boost;
    logic gain;
    logic mul1;
    logic mul2;
    logic mul3;
    logic prof;
    logic div_prof;
    logic fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic need_bdiv;
    logic need_pdiv;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ----- design/smp_div.sv -----
// ----------------------------------------------------------------------------
// smp_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, quotient held until the
// next start.
// ----------------------------------------------------------------------------
module smp_div #(
  parameter int DW = 39,
  parameter int DV = 23
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DV-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quo
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DV-1:0]    rem;
  logic [DV-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic [DV:0]      sh;
  logic             take;

  assign sh     = {rem, quo[DW-1]};
  assign take   = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= take ? DV'(sh - {1'b0, dvs}) : sh[DV-1:0];
      quo <= {quo[DW-2:0], take};
    end
  end

endmodule

// ----- design/smp_datapath.sv -----
// ----------------------------------------------------------------------------
// smp_datapath: arithmetic and registers of the motion profile
// Config registers, baselines, drift boost, profile level, output register.
// ----------------------------------------------------------------------------
module smp_datapath #(
  parameter int POS_BITS       = smp_pkg::POS_BITS_DEF,
  parameter int GAIN_FRAC_BITS = smp_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [2:0]      cfg_index,
  input  logic [9:0]      cfg_data,
  input  logic [47:0]     s_tdata,
  input  logic            s_tuser,
  input  smp_pkg::cmd_t   cmd,
  output smp_pkg::status_t status,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [31:0]     m_tdata
);

  localparam int PB  = POS_BITS;
  localparam int GF  = GAIN_FRAC_BITS;
  localparam int AW  = PB + 9;
  localparam int DW  = (PB + 9 > 39) ? PB + 9 : 39;
  localparam int DV  = 23;
  localparam int CW  = (PB + 5 > 27) ? PB + 5 : 27;
  localparam int GW  = GF + 11;
  localparam int CQW = GF + 9;
  localparam int KW  = GF + 2;
  localparam int KPW = 2 * GF + 11;
  localparam int PW  = GF + 32;

  localparam int G_SLOW = ((7 << (GF + 1)) + 10) / 20;
  localparam int G_FAST = ((3 << (GF + 1)) + 2) / 4;
  localparam int K_SLOW = ((1 << (GF + 1)) + 2) / 4;
  localparam int K_FAST = ((77 << (GF + 1)) + 20) / 40;

  // divide by ten through a reciprocal, exact below 2^18
  localparam int R10_W = 18;
  localparam int RCP10 = 52429;
  localparam int SAT10 = (1 << R10_W) - 1;

  // configuration
  logic [9:0] distance;
  logic [6:0] speed;
  logic       rev;
  logic [2:0] mode;
  logic [9:0] cpc;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance <= '0;
      speed    <= 7'd50;
      rev      <= 1'b0;
      mode     <= smp_pkg::MODE_FULL;
      cpc      <= 10'd20;
    end else if (cfg_valid) begin
      case (cfg_index)
        smp_pkg::CFG_DISTANCE: distance <= cfg_data;
        smp_pkg::CFG_SPEED:    speed    <= cfg_data[6:0];
        smp_pkg::CFG_REVERSE:  rev      <= cfg_data[0];
        smp_pkg::CFG_MODE:     mode     <= cfg_data[2:0];
        smp_pkg::CFG_CPC:      cpc      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [9:0]  cpc_e;
  logic [6:0]  v_e;
  logic [2:0]  mode_e;
  logic        lng;
  logic        fast;

  assign cpc_e  = (cpc == '0) ? 10'd1 : cpc;
  assign v_e    = (speed > 7'd100) ? 7'd100 : speed;
  assign mode_e = (mode > smp_pkg::MODE_ACC_CONST) ? smp_pkg::MODE_FULL : mode;
  assign lng    = distance >= 10'(smp_pkg::LONG_CM);
  assign fast   = v_e >= 7'd50;

  // item and state registers
  logic               kind_r;
  logic signed [23:0] lsum_r, rsum_r;
  logic signed [23:0] base_left, base_right;
  logic               finished;

  logic signed [PB-1:0] dl, dr;
  logic [19:0]          tgt;
  logic [13:0]          vmax;
  logic signed [PB:0]   x8;
  logic [PB:0]          ax8;
  logic                 d4_pos, d4_neg, a_big;
  logic [10:0]          a;
  logic                 ended_t, in_acc, in_cru;
  logic [GW-1:0]        g;
  logic [PW-1:0]        p;
  logic [16:0]          bmag;
  smp_pkg::branch_t     br;
  logic signed [AW-1:0] kx;
  logic                 pneg;
  logic [DW-1:0]        pnum;
  logic [R10_W-1:0]     n10;
  logic [14:0]          q10;
  logic                 rnz10;
  logic signed [14:0]   res_l, res_r;
  logic                 res_done;

  // divider
  logic          div_start, div_busy;
  logic [DW-1:0] div_a, quo;
  logic [DV-1:0] div_b;
  logic [22:0]   t8;

  assign t8        = {tgt, 3'b000};
  assign div_start = cmd.div_boost | cmd.div_prof;
  assign div_a     = cmd.div_boost ? (DW'(a) << GF) : pnum;
  assign div_b     = cmd.div_boost ? DV'({cpc_e, 2'b00}) : t8;

  smp_div #(.DW(DW), .DV(DV)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quo      (quo)
  );

  // status
  logic need_bdiv;
  assign need_bdiv = (d4_pos | d4_neg) & ~a_big & ({1'b0, a} >= {cpc_e, 2'b00});

  assign status.bypass    = ~kind_r | finished;
  assign status.need_bdiv = need_bdiv;
  assign status.need_pdiv = br == smp_pkg::BR_DEC;
  assign status.div_done  = ~div_busy;
  assign status.out_free  = ~m_tvalid | m_tready;

  // prep 1: travel since baseline
  logic signed [24:0] dl_diff, dr_diff;
  assign dl_diff = {lsum_r[23], lsum_r} - {base_left[23], base_left};
  assign dr_diff = {rsum_r[23], rsum_r} - {base_right[23], base_right};

  // prep 2: average travel and drift
  logic [PB-1:0]      adl, adr;
  logic signed [PB:0] x8_c, d4_c;
  logic [PB:0]        ad4;
  assign adl  = dl[PB-1] ? (~dl + 1'b1) : dl;
  assign adr  = dr[PB-1] ? (~dr + 1'b1) : dr;
  assign x8_c = $signed({dl[PB-1], dl}) + $signed({dr[PB-1], dr});
  assign d4_c = $signed({1'b0, adl}) - $signed({1'b0, adr});
  assign ad4  = d4_c[PB] ? (~d4_c + 1'b1) : d4_c;

  // gain step
  logic [KW-1:0]  kq;
  logic [KPW-1:0] kprod;
  logic [CW-1:0]  ax8_w, tgt_w;
  assign kq    = fast ? KW'(K_FAST) : KW'(K_SLOW);
  assign kprod = KPW'(kq) * KPW'(quo[CQW-1:0]);
  assign ax8_w = CW'(ax8);
  assign tgt_w = CW'(tgt);

  // boost scaling
  logic [PW+6:0] p120;
  logic [PW+6:0] bsh;
  assign p120 = (PW + 7)'(p) * (PW + 7)'(120);
  assign bsh  = p120 >> (GF + 2);

  // profile selection
  smp_pkg::branch_t     br_c;
  logic [6:0]           kc;
  logic signed [AW-1:0] kx_c;
  logic [AW-1:0]        akx;
  logic [15:0]          fv;
  logic [22:0]          room;
  logic [DW-1:0]        dnum;

  always_comb begin
    kc = 7'd27;
    if (ended_t) begin
      br_c = smp_pkg::BR_END;
    end else if (mode_e == smp_pkg::MODE_CONST) begin
      br_c = smp_pkg::BR_CONST;
    end else if (mode_e == smp_pkg::MODE_ACCEL) begin
      br_c = smp_pkg::BR_ACC;
      kc   = lng ? 7'd9 : 7'd63;
    end else if (mode_e != smp_pkg::MODE_DECEL && in_acc) begin
      br_c = smp_pkg::BR_ACC;
      kc   = lng ? 7'd27 : 7'd93;
    end else if (mode_e == smp_pkg::MODE_ACC_CONST ||
                 (mode_e == smp_pkg::MODE_FULL && in_cru)) begin
      br_c = smp_pkg::BR_CONST;
    end else begin
      br_c = smp_pkg::BR_DEC;
    end
  end

  assign kx_c = AW'(x8) * $signed(AW'(kc));
  assign akx  = kx_c[AW-1] ? (~kx_c + 1'b1) : kx_c;
  assign fv   = ((mode_e == smp_pkg::MODE_DECEL || lng) ? 16'd600 : 16'd300) * 16'(v_e);
  assign room = 23'(CW'(t8) - ax8_w);
  assign dnum = DW'(room) * DW'(fv);

  // short ramp tenth: a saturated numerator still clamps to the same side
  logic [R10_W+15:0] p10;
  assign p10 = (R10_W + 16)'(n10) * (R10_W + 16)'(RCP10);

  // low product bits reach one tenth exactly when the remainder is nonzero
  always_ff @(posedge clk) begin
    q10   <= p10[R10_W+15:19];
    rnz10 <= p10[18:0] >= 19'(RCP10);
  end

  // final level
  logic signed [AW-1:0] q_w, f_w, acc_raw, vm_w;
  logic signed [14:0]   vm_s, cv;
  logic [13:0]          qm;
  logic                 end_f;
  logic signed [18:0]   sb, l_raw, r_raw;
  logic signed [14:0]   l_sat, r_sat;

  assign q_w  = $signed(AW'(q10));
  assign vm_w = $signed(AW'(vmax));
  assign vm_s = $signed({1'b0, vmax});

  always_comb begin
    end_f   = 1'b0;
    cv      = '0;
    qm      = (quo > DW'(vmax)) ? vmax : quo[13:0];
    f_w     = lng ? (kx >>> 2) : (pneg ? -(q_w + $signed(AW'(rnz10))) : q_w);
    acc_raw = (rev ? -$signed(AW'(lng ? 2280 : 2520)) : $signed(AW'(lng ? 2280 : 2520))) + f_w;
    case (br)
      smp_pkg::BR_END: begin
        end_f = 1'b1;
      end
      smp_pkg::BR_CONST: begin
        cv = rev ? -vm_s : vm_s;
      end
      smp_pkg::BR_ACC: begin
        if (acc_raw > vm_w) begin
          cv = vm_s;
        end else if (acc_raw < -vm_w) begin
          cv = -vm_s;
        end else begin
          cv = 15'(acc_raw);
        end
      end
      default: begin
        if (v_e == '0) begin
          end_f = 1'b1;
        end
        if (qm <= 14'(smp_pkg::MIN_MV)) begin
          qm = 14'(smp_pkg::MIN_MV);
        end
        cv = rev ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      end
    endcase
  end

  assign sb    = rev ? -$signed({2'b00, bmag}) : $signed({2'b00, bmag});
  assign l_raw = 19'(cv) + (d4_neg ? sb : 19'sd0);
  assign r_raw = 19'(cv) + (d4_pos ? sb : 19'sd0);
  assign l_sat = (l_raw > 19'sd12000) ? 15'sd12000 :
                 (l_raw < -19'sd12000) ? -15'sd12000 : 15'(l_raw);
  assign r_sat = (r_raw > 19'sd12000) ? 15'sd12000 :
                 (r_raw < -19'sd12000) ? -15'sd12000 : 15'(r_raw);

  // control state of the move
  always_ff @(posedge clk) begin
    if (rst) begin
      base_left  <= '0;
      base_right <= '0;
      finished   <= 1'b1;
    end else if (cmd.prep1 && !kind_r) begin
      base_left  <= lsum_r;
      base_right <= rsum_r;
      finished   <= 1'b0;
    end else if (cmd.fin && end_f) begin
      finished <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= s_tuser;
      lsum_r <= s_tdata[23:0];
      rsum_r <= s_tdata[47:24];
    end
    if (cmd.prep1) begin
      dl    <= PB'(dl_diff);
      dr    <= PB'(dr_diff);
      tgt   <= 20'(distance) * 20'(cpc_e);
      vmax  <= 14'(v_e) * 14'd120;
      res_l <= '0;
      res_r <= '0;
      res_done <= kind_r;
    end
    if (cmd.prep2) begin
      x8     <= x8_c;
      ax8    <= x8_c[PB] ? (~x8_c + 1'b1) : x8_c;
      d4_pos <= ~d4_c[PB] & (d4_c != '0);
      d4_neg <= d4_c[PB];
      a_big  <= ad4 >= (PB + 1)'(smp_pkg::BIG_DRIFT);
      a      <= ad4[10:0];
    end
    if (cmd.gain) begin
      ended_t <= ax8_w >= CW'(t8);
      in_acc  <= ax8_w * 10 < tgt_w * 24;
      in_cru  <= ax8_w * 10 < tgt_w * (lng ? 64 : 48);
      g       <= (fast ? GW'(G_FAST) : GW'(G_SLOW)) +
                 (need_bdiv ? GW'(kprod >> GF) : GW'(0));
    end
    if (cmd.mul1) begin
      p <= PW'(g) * PW'(a);
    end
    if (cmd.mul2) begin
      p <= p * PW'(cpc_e);
    end
    if (cmd.mul3) begin
      if (a_big) begin
        bmag <= 17'(smp_pkg::BOOST_CAP);
      end else if (!(d4_pos | d4_neg)) begin
        bmag <= '0;
      end else if (bsh > (PW + 7)'(smp_pkg::BOOST_CAP)) begin
        bmag <= 17'(smp_pkg::BOOST_CAP);
      end else begin
        bmag <= 17'(bsh);
      end
    end
    if (cmd.prof) begin
      br   <= br_c;
      kx   <= kx_c;
      pneg <= kx_c[AW-1];
      pnum <= dnum;
      n10  <= (akx > AW'(SAT10)) ? R10_W'(SAT10) : akx[R10_W-1:0];
    end
    if (cmd.fin) begin
      res_l    <= end_f ? 15'sd0 : l_sat;
      res_r    <= end_f ? 15'sd0 : r_sat;
      res_done <= end_f;
    end
    if (cmd.emit) begin
      m_tdata <= {1'b0, res_done, res_r, res_l};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ----- design/smp_ctrl.sv -----
// ----------------------------------------------------------------------------
// smp_ctrl: sequencer of the motion profile
// Steps the datapath through prep, boost, profile and emit phases.
// ----------------------------------------------------------------------------
module smp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  smp_pkg::status_t status,
  output smp_pkg::cmd_t    cmd
);

  smp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      smp_pkg::S_IDLE:  if (in_valid) state_next = smp_pkg::S_P1;
      smp_pkg::S_P1:    state_next = status.bypass ? smp_pkg::S_EMIT : smp_pkg::S_P2;
      smp_pkg::S_P2:    state_next = smp_pkg::S_B0;
      smp_pkg::S_B0:    state_next = status.need_bdiv ? smp_pkg::S_BWAIT : smp_pkg::S_GAIN;
      smp_pkg::S_BWAIT: if (status.div_done) state_next = smp_pkg::S_GAIN;
      smp_pkg::S_GAIN:  state_next = smp_pkg::S_M1;
      smp_pkg::S_M1:    state_next = smp_pkg::S_M2;
      smp_pkg::S_M2:    state_next = smp_pkg::S_M3;
      smp_pkg::S_M3:    state_next = smp_pkg::S_PROF;
      smp_pkg::S_PROF:  state_next = smp_pkg::S_PD0;
      smp_pkg::S_PD0:   state_next = status.need_pdiv ? smp_pkg::S_PWAIT : smp_pkg::S_FIN;
      smp_pkg::S_PWAIT: if (status.div_done) state_next = smp_pkg::S_FIN;
      smp_pkg::S_FIN:   state_next = smp_pkg::S_EMIT;
      smp_pkg::S_EMIT:  if (status.out_free) state_next = smp_pkg::S_IDLE;
      default:          state_next = smp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      smp_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      smp_pkg::S_P1:   cmd.prep1 = 1'b1;
      smp_pkg::S_P2:   cmd.prep2 = 1'b1;
      smp_pkg::S_B0:   cmd.div_boost = status.need_bdiv;
      smp_pkg::S_GAIN: cmd.gain = 1'b1;
      smp_pkg::S_M1:   cmd.mul1 = 1'b1;
      smp_pkg::S_M2:   cmd.mul2 = 1'b1;
      smp_pkg::S_M3:   cmd.mul3 = 1'b1;
      smp_pkg::S_PROF: cmd.prof = 1'b1;
      smp_pkg::S_PD0:  cmd.div_prof = status.need_pdiv;
      smp_pkg::S_FIN:  cmd.fin = 1'b1;
      smp_pkg::S_EMIT: cmd.emit = status.out_free;
      default: ;
    endcase
  end

endmodule

// ----- design/straight_drive_motion_profile.sv -----
// ----------------------------------------------------------------------------
// straight_drive_motion_profile: drift-corrected straight drive profile
// Turns left/right encoder sums into saturated left/right drive millivolts.
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one item per transfer; s_tuser is the kind (0 start move and
//     latch baseline, 1 encoder tick), s_tdata carries the two encoder sums
//   m_* channel: one result per item, left/right drive in mV and done flag
//   cfg_* channel: register writes, always ready; write only while the block idles (not enforced)
// sequencing
//   a start item, or a tick after the move ended, goes from prep straight to emit
//   a tick steps through prep, boost, profile and emit, plus one serial divide per
//   divide needed: the drift gain divide and the decel divide
//   (divider width DW = 39 at the default widths)
//   both divides use the shared bit-serial divider; one item is in work at a time
// reset
//   registers go to their reset values and the move is idle (done) until a
//   start item arrives; no result is pending
// stalls
//   a result sits in the output register; the next item is taken meanwhile
//   and its result waits only if the previous one has not left yet
module straight_drive_motion_profile #(
  parameter int POS_BITS       = smp_pkg::POS_BITS_DEF,
  parameter int GAIN_FRAC_BITS = smp_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // left_sum [23:0], right_sum [47:24]
  input  logic        s_tuser,   // kind
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // left_drive [14:0], right_drive [29:15], done_res [30]
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  smp_pkg::cmd_t    cmd;
  smp_pkg::status_t status;

  // register writes are taken at once
  assign cfg_ready = 1'b1;

  smp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  smp_datapath #(
    .POS_BITS       (POS_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for straight_drive_motion_profile
// Streams start and encoder tick items through the block under several register
// settings, predicts every drive/done result and compares field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 1500000;

  typedef struct packed {
    logic        done;
    logic [14:0] right;
    logic [14:0] left;
  } drive_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = smp_pkg::CFG_DISTANCE;
  logic [9:0] cfg_data = '0;

  // predictor copy of the registers and move state
  int unsigned dist_cm, spd, rev, pmode, cpc_reg;
  logic [23:0] home_l, home_r;
  bit move_over;

  drive_t drives_due[$];
  int unsigned n_sent, n_got, n_bad, n_done, cycles;
  int unsigned hold_off;   // long receiver stall requested by a test
  bit rx_random = 1'b1;

  always #4 clk = ~clk;

  straight_drive_motion_profile dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // cycle counter with a hard limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout at %0t", $time);
      $display("straight_drive_motion_profile test failed");
      $finish;
    end
  end

  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint clip(longint a, longint t);
    return a > t ? t : (a < -t ? -t : a);
  endfunction

  function automatic longint q_gain(longint num, longint den);
    return ((num <<< (smp_pkg::GAIN_FRAC_BITS_DEF + 1)) + den) / (2 * den);
  endfunction

  // drift boost in mV for quarter-degree drift a
  function automatic longint drift_boost(longint a, longint cpc, bit fast);
    longint g, cmq, b;
    if (a >= smp_pkg::BIG_DRIFT) return smp_pkg::BOOST_CAP;
    g = fast ? q_gain(3, 2) : q_gain(7, 10);
    if (a >= 4 * cpc) begin
      cmq = (a <<< smp_pkg::GAIN_FRAC_BITS_DEF) / (4 * cpc);
      g += ((fast ? q_gain(77, 20) : q_gain(1, 2)) * cmq) >>> smp_pkg::GAIN_FRAC_BITS_DEF;
    end
    b = (120 * g * a * cpc) >>> (smp_pkg::GAIN_FRAC_BITS_DEF + 2);
    return b > smp_pkg::BOOST_CAP ? smp_pkg::BOOST_CAP : b;
  endfunction

  function automatic drive_t pack_drive(longint l, longint r, bit dn);
    drive_t d;
    d.left = 15'(clip(l, smp_pkg::DRIVE_MAX));
    d.right = 15'(clip(r, smp_pkg::DRIVE_MAX));
    d.done = dn;
    return d;
  endfunction

  // expected result for one item, updates the move state
  function automatic drive_t predict_drive(bit kind, logic [23:0] ls, logic [23:0] rs);
    longint dl, dr, x8, ax8, d4, cpc, tgt, v, vmax, s, cv, bst, lb, rb, fac, mag;
    bit lng, fast, ended;
    int unsigned md;
    lb = 0; rb = 0; ended = 0;
    if (!kind) begin
      home_l = ls; home_r = rs; move_over = 0;
      return pack_drive(0, 0, 0);
    end
    if (move_over) return pack_drive(0, 0, 1);
    dl = longint'($signed(24'(ls - home_l)));
    dr = longint'($signed(24'(rs - home_r)));
    cpc = cpc_reg == 0 ? 1 : cpc_reg;
    tgt = longint'(dist_cm) * cpc;
    v = spd > 100 ? 100 : spd;
    vmax = 120 * v;
    s = rev ? -1 : 1;
    lng = dist_cm >= smp_pkg::LONG_CM;
    fast = v >= 50;
    md = pmode > 4 ? 0 : pmode;
    d4 = (dl < 0 ? -dl : dl) - (dr < 0 ? -dr : dr);
    if (d4 != 0) begin
      bst = s * drift_boost(d4 < 0 ? -d4 : d4, cpc, fast);
      if (d4 > 0) rb = bst; else lb = bst;
    end
    x8 = dl + dr;
    ax8 = x8 < 0 ? -x8 : x8;
    if (ax8 >= 8 * tgt) begin
      ended = 1; cv = 0;
    end else if (md == smp_pkg::MODE_CONST) begin
      cv = s * vmax;
    end else if (md == smp_pkg::MODE_ACCEL) begin
      cv = lng ? s * 2280 + fdiv(9 * x8, 4) : s * 2520 + fdiv(63 * x8, 10);
      cv = clip(cv, vmax);
    end else if (md != smp_pkg::MODE_DECEL && 10 * ax8 < 24 * tgt) begin
      cv = lng ? s * 2280 + fdiv(27 * x8, 4) : s * 2520 + fdiv(93 * x8, 10);
      cv = clip(cv, vmax);
    end else if (md == smp_pkg::MODE_ACC_CONST ||
                 (md == smp_pkg::MODE_FULL && 10 * ax8 < (lng ? 64 : 48) * tgt)) begin
      cv = s * vmax;
    end else begin
      fac = (md == smp_pkg::MODE_DECEL || lng) ? 600 : 300;
      mag = ((8 * tgt - ax8) * fac * v) / (8 * tgt);
      if (mag > vmax) mag = vmax;
      if (v == 0) begin
        ended = 1; mag = 0;
      end else if (mag <= smp_pkg::MIN_MV) begin
        mag = smp_pkg::MIN_MV;
      end
      cv = s * mag;
    end
    if (ended) begin
      move_over = 1;
      return pack_drive(0, 0, 1);
    end
    return pack_drive(cv + lb, cv + rb, 0);
  endfunction

  // receiver: random stalls, plus a long hold-off when a test asks for it
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= rx_random ? ($urandom_range(0, 3) == 0 ? 1'b0 : 1'b1) : 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    drive_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[30:0];
      n_got++;
      if (drives_due.size() == 0) begin
        n_bad++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = drives_due.pop_front();
        if (got.done) n_done++;
        if (got.left !== want.left) begin
          n_bad++;
          $display("%0t: left_drive expected %0d actual %0d", $time,
                   $signed(want.left), $signed(got.left));
        end
        if (got.right !== want.right) begin
          n_bad++;
          $display("%0t: right_drive expected %0d actual %0d", $time,
                   $signed(want.right), $signed(got.right));
        end
        if (got.done !== want.done) begin
          n_bad++;
          $display("%0t: done_res expected %0d actual %0d", $time, want.done, got.done);
        end
      end
    end
  end

  // one item transfer, with a random gap in front
  task automatic send_item(bit kind, logic [23:0] ls, logic [23:0] rs);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {rs, ls};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    drives_due.push_back(predict_drive(kind, ls, rs));
    n_sent++;
  endtask

  // drain and let the block go quiet before a register write
  task automatic settle;
    s_tvalid <= 1'b0;
    while (drives_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 10'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      smp_pkg::CFG_DISTANCE: dist_cm = val & 10'h3ff;
      smp_pkg::CFG_SPEED:    spd = val & 7'h7f;
      smp_pkg::CFG_REVERSE:  rev = val & 1;
      smp_pkg::CFG_MODE:     pmode = val & 7;
      smp_pkg::CFG_CPC:      cpc_reg = val & 10'h3ff;
      default: ;
    endcase
  endtask

  task automatic set_all(int unsigned d, int unsigned sp, int unsigned rv,
                         int unsigned md, int unsigned cpc);
    settle();
    write_reg(smp_pkg::CFG_DISTANCE, d);
    write_reg(smp_pkg::CFG_SPEED, sp);
    write_reg(smp_pkg::CFG_REVERSE, rv);
    write_reg(smp_pkg::CFG_MODE, md);
    write_reg(smp_pkg::CFG_CPC, cpc);
    cfg_valid <= 1'b0;
  endtask

  // directed: field extremes, each mode, finished ticks, big drift, zero target
  task automatic test_directed;
    send_item(1, 24'h000000, 24'h000000);          // tick while idle after reset
    set_all(30, 100, 0, smp_pkg::MODE_FULL, 20);
    send_item(0, 24'h000000, 24'h000000);
    send_item(1, 24'd100, 24'd100);                // accel
    send_item(1, 24'd2000, 24'd100);               // large drift, right boosted
    send_item(1, 24'd100, 24'd2000);               // large drift, left boosted
    send_item(1, 24'd3000, 24'd3000);              // reaches target
    send_item(1, 24'd4000, 24'd4100);              // sticky done
    send_item(1, 24'd5000, 24'd5000);              // sticky done
    send_item(1, 24'd10, 24'd10);                  // sticky done
    send_item(0, 24'h7fffff, 24'h800000);
    send_item(1, 24'h800000, 24'h7fffff);          // wrapped travel
    send_item(0, 24'hffffff, 24'h000001);
    send_item(1, 24'h000001, 24'hffffff);
    set_all(0, 0, 1, 7, 0);                        // zero target, odd mode, cpc 0
    send_item(0, 24'd0, 24'd0);
    send_item(1, 24'd0, 24'd0);
    set_all(1023, 127, 1, smp_pkg::MODE_DECEL, 1023);
    send_item(0, 24'd0, 24'd0);
    send_item(1, -24'd50000, -24'd50010);
    set_all(10, 0, 0, smp_pkg::MODE_DECEL, 1);     // speed 0 in decel ends the move
    send_item(0, 24'd0, 24'd0);
    send_item(1, 24'd5, 24'd5);
    for (int m = smp_pkg::MODE_ACCEL; m <= smp_pkg::MODE_ACC_CONST; m++) begin
      set_all(12, 40, m[0], m, 7);
      send_item(0, 24'd0, 24'd0);
      send_item(1, 24'd30, 24'd25);
    end
  endtask

  // random moves: start, then a walk of ticks toward and past the target
  task automatic test_random_moves(int unsigned n_items);
    int unsigned left_n, d, cpc, steps;
    logic [23:0] bl, br, pl, pr;
    int sgn;
    left_n = n_items;
    while (left_n > 0) begin
      case ($urandom_range(0, 3))
        0: d = $urandom_range(0, 1023);
        1: d = $urandom_range(0, 40);
        default: d = $urandom_range(5, 60);
      endcase
      cpc = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(1, 40);
      set_all(d, $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 100),
              $urandom_range(0, 1), $urandom_range(0, 7), cpc);
      steps = $urandom_range(10, 40);
      for (int k = 0; k < 4 && left_n > 0; k++) begin
        bl = 24'($urandom()); br = 24'($urandom());
        sgn = ($urandom_range(0, 1) != 0) ? -1 : 1;
        send_item(0, bl, br);
        left_n--;
        pl = bl; pr = br;
        for (int i = 0; i < steps && left_n > 0; i++) begin
          if ($urandom_range(0, 15) == 0) begin
            send_item(1'($urandom_range(0, 1)), 24'($urandom()), 24'($urandom()));   // noise
          end else begin
            pl = pl + 24'(sgn * int'(((d * 3 + 1) * (cpc + 1)) / steps)
                          + $urandom_range(0, 40) - 20);
            pr = pr + 24'(sgn * int'(((d * 3 + 1) * (cpc + 1)) / steps)
                          + $urandom_range(0, 40) - 20);
            send_item(1, pl, pr);
          end
          left_n--;
        end
      end
    end
  endtask

  // receiver held off a long time while items keep coming
  task automatic test_backpressure;
    set_all(50, 60, 0, smp_pkg::MODE_FULL, 10);
    hold_off = 600;
    send_item(0, 24'd0, 24'd0);
    for (int i = 1; i <= 20; i++) send_item(1, 24'(i * 150), 24'(i * 151));
  endtask

  initial begin
    dist_cm = 0; spd = 50; rev = 0; pmode = smp_pkg::MODE_FULL; cpc_reg = 20;
    home_l = '0; home_r = '0; move_over = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    rx_random = 1'b1;
    test_random_moves(650);
    rx_random = 1'b0;
    test_random_moves(40);
    s_tvalid <= 1'b0;
    while (drives_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("ran %0d items, %0d results checked (%0d with done set)",
             n_sent, n_got, n_done);
    $display("covered every profile mode, both directions, stalls and %0d mismatches", n_bad);
    if (n_bad == 0 && drives_due.size() == 0)
      $display("straight_drive_motion_profile test passed");
    else
      $display("straight_drive_motion_profile test failed");
    $finish;
  end
endmodule
